### sv/delta_matroid_exchange_check_unit_macros.svh
// Assertion macros shared by the exchange check unit
`ifndef DELTA_MATROID_EXCHANGE_CHECK_UNIT_MACROS_SVH
`define DELTA_MATROID_EXCHANGE_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dmx_pkg.sv
// Package: constants, sequencer states and probe flags of the exchange check unit
`timescale 1ns / 1ps
package dmx_pkg;

  localparam int DMX_GROUND_BITS = 16;
  localparam int DMX_MAX_SETS    = 64;
  localparam int DMX_MASK_BITS   = 16;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_LOAD,
    ST_PAIR,
    ST_RD_J,
    ST_DIF,
    ST_XSCAN,
    ST_YSCAN,
    ST_TEST,
    ST_DONE,
    ST_WIPE_RD,
    ST_WIPE_WR
  } dmx_state_t;

  typedef struct packed {
    logic x_end;
    logic x_hit;
    logic y_end;
    logic y_hit;
  } probe_t;

endpackage

### sv/dmx_if.sv
// Channel interfaces: set input and check result
`timescale 1ns / 1ps
interface dmx_in_if
  import dmx_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DMX_MASK_BITS-1:0] set_mask;
  logic                     last_set;

  modport source (output valid, output set_mask, output last_set, input ready);
  modport sink   (input valid, input set_mask, input last_set, output ready);
endinterface

interface dmx_out_if;
  logic valid;
  logic ready;
  logic axiom_holds;
  logic overflowed;

  modport source (output valid, output axiom_holds, output overflowed, input ready);
  modport sink   (input valid, input axiom_holds, input overflowed, output ready);
endinterface

### sv/dmx_ram.sv
// Generic RAM: one write port, one read port with registered read data
`timescale 1ns / 1ps
module dmx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dmx_probe.sv
// Exchange probe unit: element tests and candidate set for one (x, y) step
`timescale 1ns / 1ps
module dmx_probe
  import dmx_pkg::*;
#(
  parameter int GROUND_BITS = DMX_GROUND_BITS
) (
  input  logic [GROUND_BITS-1:0]           f1,
  input  logic [GROUND_BITS-1:0]           dif,
  input  logic [$clog2(GROUND_BITS+1)-1:0] x,
  input  logic [$clog2(GROUND_BITS+1)-1:0] y,
  output probe_t                           flags,
  output logic [GROUND_BITS-1:0]           cand
);

  localparam int XW  = $clog2(GROUND_BITS + 1);
  localparam int XIW = $clog2(GROUND_BITS);

  logic [GROUND_BITS-1:0] x_bit;
  logic [GROUND_BITS-1:0] y_bit;

  always_comb begin
    flags.x_end = (x == XW'(GROUND_BITS));
    flags.y_end = (y == XW'(GROUND_BITS));
    flags.x_hit = !flags.x_end && dif[x[XIW-1:0]];
    flags.y_hit = !flags.y_end && dif[y[XIW-1:0]];
    x_bit = GROUND_BITS'(1) << x[XIW-1:0];
    y_bit = GROUND_BITS'(1) << y[XIW-1:0];
    // y equal to x flips just the one element
    cand = f1 ^ (x_bit | y_bit);
  end

endmodule

### sv/delta_matroid_exchange_check_unit.sv
// Top level: delta-matroid symmetric exchange checker over a loaded set family
//
//   channel  | dir | payload                    | handshake
//   ---------+-----+----------------------------+-------------
//   in_ch    | in  | set_mask[15:0], last_set   | valid/ready
//   out_ch   | out | axiom_holds, overflowed    | valid/ready
//
// Load: one set item per cycle while in_ch.ready is high; ready drops after last_set.
// Check: each ordered pair of distinct stored sets is read, then each ground element x is
//   scanned; each x in the difference scans y positions and probes the membership map for
//   each y in the difference. One probe unit and one map read port do this. Early exit on failure.
// Wipe: the map bits of the stored sets are cleared; the result waits in an output register, a new run loads.
// After reset the membership map is swept clear before in_ch.ready first rises.
`timescale 1ns / 1ps
`include "delta_matroid_exchange_check_unit_macros.svh"
module delta_matroid_exchange_check_unit
  import dmx_pkg::*;
#(
  parameter int GROUND_BITS = DMX_GROUND_BITS,
  parameter int MAX_SETS    = DMX_MAX_SETS
) (
  input  logic     clk,
  input  logic     rst_n,
  dmx_in_if.sink   in_ch,
  dmx_out_if.source out_ch
);

  localparam int CW  = $clog2(MAX_SETS + 1);
  localparam int AW  = $clog2(MAX_SETS);
  localparam int XW  = $clog2(GROUND_BITS + 1);
  localparam int IW  = (GROUND_BITS < DMX_MASK_BITS) ? GROUND_BITS : DMX_MASK_BITS;

  dmx_state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [XW-1:0]          x_r, x_nxt;
  logic [XW-1:0]          y_r, y_nxt;
  logic [GROUND_BITS-1:0] f1_r, f1_nxt;
  logic [GROUND_BITS-1:0] dif_r, dif_nxt;
  logic [GROUND_BITS-1:0] sweep_r, sweep_nxt;
  logic                   holds_r, holds_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_holds_r, out_holds_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic [GROUND_BITS-1:0] s_in;
  logic                   in_acc;

  logic                   st_we;
  logic [AW-1:0]          st_raddr;
  logic [GROUND_BITS-1:0] st_rdata;

  logic                   map_we;
  logic [GROUND_BITS-1:0] map_waddr;
  logic                   map_wdata;
  logic                   map_rdata;

  probe_t                 probe;
  logic [GROUND_BITS-1:0] cand;

  dmx_ram #(
    .WIDTH (GROUND_BITS),
    .DEPTH (MAX_SETS)
  ) u_set_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[AW-1:0]),
    .wdata (s_in),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  dmx_ram #(
    .WIDTH (1),
    .DEPTH (2 ** GROUND_BITS)
  ) u_member_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (cand),
    .rdata (map_rdata)
  );

  dmx_probe #(
    .GROUND_BITS (GROUND_BITS)
  ) u_probe (
    .f1    (f1_r),
    .dif   (dif_r),
    .x     (x_r),
    .y     (y_r),
    .flags (probe),
    .cand  (cand)
  );

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.axiom_holds = out_holds_r;
  assign out_ch.overflowed  = out_ovf_r;
  assign st_raddr           = (state_r == ST_RD_J) ? j_r[AW-1:0] : i_r[AW-1:0];

  always_comb begin
    s_in         = '0;
    s_in[IW-1:0] = in_ch.set_mask[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    f1_r        <= f1_nxt;
    dif_r       <= dif_nxt;
    holds_r     <= holds_nxt;
    out_holds_r <= out_holds_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    f1_nxt        = f1_r;
    dif_nxt       = dif_r;
    sweep_nxt     = sweep_r;
    holds_nxt     = holds_r;
    out_holds_nxt = out_holds_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r;
    st_we         = 1'b0;
    map_we        = 1'b0;
    map_waddr     = s_in;
    map_wdata     = 1'b1;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        map_we    = 1'b1;
        map_waddr = sweep_r;
        map_wdata = 1'b0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_SETS)) begin
            st_we     = 1'b1;
            map_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_set) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        if (i_r == count_r) begin
          holds_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (j_r == count_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else if (i_r == j_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = ST_RD_J;
        end
      end
      ST_RD_J: begin
        f1_nxt    = st_rdata;
        state_nxt = ST_DIF;
      end
      ST_DIF: begin
        dif_nxt   = f1_r ^ st_rdata;
        x_nxt     = '0;
        state_nxt = ST_XSCAN;
      end
      ST_XSCAN: begin
        if (probe.x_end) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_PAIR;
        end else if (probe.x_hit) begin
          y_nxt     = '0;
          state_nxt = ST_YSCAN;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_YSCAN: begin
        // no exchange partner for x: the family fails
        if (probe.y_end) begin
          holds_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else if (probe.y_hit) begin
          state_nxt = ST_TEST;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end
      ST_TEST: begin
        if (map_rdata) begin
          x_nxt     = x_r + 1'b1;
          state_nxt = ST_XSCAN;
        end else begin
          y_nxt     = y_r + 1'b1;
          state_nxt = ST_YSCAN;
        end
      end
      ST_DONE: begin
        // hold until the previous result has left the output register
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_holds_nxt = holds_r;
          out_ovf_nxt   = ovf_r;
          i_nxt         = '0;
          state_nxt     = ST_WIPE_RD;
        end
      end
      ST_WIPE_RD: begin
        if (i_r == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_WIPE_WR;
        end
      end
      ST_WIPE_WR: begin
        map_we    = 1'b1;
        map_waddr = st_rdata;
        map_wdata = 1'b0;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_WIPE_RD;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  `DMX_ASSERT_NEXT(a_last_starts_check, in_acc && in_ch.last_set, state_r == ST_PAIR, "last item did not start the check")
  `DMX_ASSERT_NOW(a_pair_distinct, state_r == ST_RD_J, i_r != j_r, "pair read with equal indexes")
  `DMX_ASSERT_NOW(a_count_bound, state_r != ST_CLR, count_r <= CW'(MAX_SETS), "set count beyond store size")

endmodule

### bench/delta_matroid_exchange_check_unit_test.sv
// Testbench for the exchange check unit: random set families checked against a scoreboard
`timescale 1ns / 1ps
module delta_matroid_exchange_check_unit_test
  import dmx_pkg::*;
;

  typedef logic [DMX_MASK_BITS-1:0] set_mask_t;

  typedef struct packed {
    logic axiom_holds;
    logic overflowed;
  } check_result_t;

  localparam set_mask_t GROUND_MASK = set_mask_t'((64'd1 << DMX_GROUND_BITS) - 1);
  localparam int SET_BUDGET = 670;

  // Holds the family loaded so far and the verdicts still owed by the block.
  class exchange_scoreboard;
    set_mask_t     loaded[$];
    bit            present[set_mask_t];
    bit            dropped;
    check_result_t awaited[$];
    int            errors;
    int            checks;
    int            held;
    int            overflows;

    // Every x in f1 ^ f2 needs some y in f1 ^ f2 with f1 ^ {x,y} in the family.
    function bit pair_exchanges(set_mask_t f1, set_mask_t f2);
      set_mask_t dif;
      set_mask_t cand;
      bit        found;
      dif = f1 ^ f2;
      for (int x = 0; x < DMX_GROUND_BITS; x++) begin
        if (dif[x]) begin
          found = 1'b0;
          for (int y = 0; y < DMX_GROUND_BITS && !found; y++) begin
            if (dif[y]) begin
              cand = f1;
              cand[x] = ~cand[x];
              if (y != x) cand[y] = ~cand[y];
              found = (present.exists(cand) != 0);
            end
          end
          if (!found) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function bit family_exchanges();
      for (int i = 0; i < loaded.size(); i++)
        for (int j = 0; j < loaded.size(); j++)
          if (i != j && !pair_exchanges(loaded[i], loaded[j])) return 1'b0;
      return 1'b1;
    endfunction

    function void note_set(set_mask_t mask, logic last);
      set_mask_t     s;
      check_result_t r;
      s = mask & GROUND_MASK;
      if (loaded.size() < DMX_MAX_SETS) begin
        loaded = {loaded, s};
        present[s] = 1'b1;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        r.axiom_holds = family_exchanges();
        r.overflowed  = dropped;
        awaited = {awaited, r};
        checks++;
        if (r.axiom_holds) held++;
        if (dropped) overflows++;
        // The block starts the next family from an empty store and map
        loaded.delete();
        present.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(logic holds, logic ovf);
      check_result_t want;
      if (awaited.size() == 0) begin
        $error("result with no check pending: axiom_holds=%0b overflowed=%0b", holds, ovf);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (holds !== want.axiom_holds) begin
          $error("axiom_holds: expected %0b, got %0b", want.axiom_holds, holds);
          errors++;
        end
        if (ovf !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, ovf);
          errors++;
        end
      end
    endfunction

    function void report_leftover();
      if (awaited.size() != 0) begin
        $error("%0d check results never arrived", awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dmx_in_if  in_ch();
  dmx_out_if out_ch();

  delta_matroid_exchange_check_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  exchange_scoreboard sb;
  set_mask_t          family[$];
  bit                 gaps_on;
  int                 sets_sent;
  int unsigned        ready_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous bound: the map sweep after reset plus the slowest family checks, many times over
  initial begin
    #400_000_000;
    $display("timeout: %0d check results still pending", sb.awaited.size());
    $display("delta_matroid_exchange_check_unit_test failed");
    $finish;
  end

  // Result side: alternate ready stretches with short and occasional long stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_left != 0) begin
        ready_left <= ready_left - 1;
      end else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        ready_left   <= ($urandom_range(99) < 80) ? $urandom_range(2) : $urandom_range(60, 8);
      end else begin
        out_ch.ready <= 1'b1;
        ready_left   <= ($urandom_range(99) < 70) ? $urandom_range(12) : $urandom_range(150, 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.axiom_holds, out_ch.overflowed);
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_set(input set_mask_t mask, input logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid    <= 1'b0;
      in_ch.set_mask <= set_mask_t'($urandom);
      in_ch.last_set <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.set_mask <= mask;
    in_ch.last_set <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_set(mask, last);
    sets_sent++;
    @(negedge clk);
  endtask

  task automatic send_family();
    gaps_on = ($urandom_range(3) != 0);
    foreach (family[i]) send_set(family[i], i == family.size() - 1);
  endtask

  function automatic set_mask_t pick_elements(int unsigned k);
    set_mask_t   m;
    int unsigned pos;
    m = '0;
    while ($countones(m) < k) begin
      pos = $urandom_range(DMX_GROUND_BITS - 1);
      m[pos] = 1'b1;
    end
    return m;
  endfunction

  // Place the low bits of code onto the set bits of support, lowest first.
  function automatic set_mask_t spread(int unsigned code, set_mask_t support);
    set_mask_t   m;
    int unsigned n;
    m = '0;
    n = 0;
    for (int b = 0; b < DMX_MASK_BITS; b++) begin
      if (support[b]) begin
        m[b] = code[n];
        n++;
      end
    end
    return m;
  endfunction

  // Append the subsets of support of size rank (every size when rank < 0), twisted.
  task automatic add_subsets(set_mask_t support, int rank, set_mask_t twist);
    int unsigned k;
    set_mask_t   s;
    k = $countones(support);
    for (int unsigned code = 0; code < (1 << k); code++) begin
      s = spread(code, support);
      if (rank < 0 || $countones(s) == rank) family = {family, s ^ twist};
    end
  endtask

  function automatic void shuffle_family();
    set_mask_t   t;
    int unsigned j;
    for (int i = family.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = family[i];
      family[i] = family[j];
      family[j] = t;
    end
  endfunction

  initial begin
    int          runs;
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    int unsigned idx;
    set_mask_t   twist;
    set_mask_t   base;

    sb = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.set_mask = '0;
    in_ch.last_set = 1'b0;
    out_ch.ready   = 1'b0;
    ready_left     = 0;
    sets_sent      = 0;
    gaps_on        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed families: lone extremes, full difference, duplicates, small known cases
    family = '{16'h0000};                                 send_family();
    family = '{16'hFFFF};                                 send_family();
    family = '{16'h0000, 16'hFFFF};                       send_family();
    family = '{16'hA5A5, 16'hA5A5};                       send_family();
    family = '{16'h0001, 16'h0000};                       send_family();
    family = '{16'h0000, 16'h4000, 16'h8000, 16'hC000};   send_family();
    family = '{16'h0003, 16'h0000};                       send_family();
    family = '{16'h0001, 16'h0002, 16'h0004};             send_family();
    family = '{16'h0000, 16'h0007};                       send_family();
    family = '{16'h5A5A, 16'h5A5B, 16'h5A58};             send_family();

    runs = 0;
    while (sets_sent < SET_BUDGET) begin
      family.delete();
      twist = set_mask_t'($urandom);
      kind  = $urandom_range(99);
      if (runs == 3 || kind < 3) begin
        // Fill the store to the brim or past it
        len = ($urandom_range(1) == 0) ? 64 + $urandom_range(1) : $urandom_range(72, 66);
        if ($urandom_range(1) == 0) begin
          add_subsets(pick_elements($urandom_range(2, 1)), -1, twist);
          while (family.size() < len)
            family = {family, family[$urandom_range(family.size() - 1)]};
        end else begin
          repeat (len) family = {family, set_mask_t'($urandom)};
        end
      end else if (kind < 33) begin
        n = ($urandom_range(9) == 0) ? 4 : $urandom_range(3);
        add_subsets(pick_elements(n), -1, twist);
      end else if (kind < 58) begin
        n = $urandom_range(5, 2);
        add_subsets(pick_elements(n), $urandom_range(n), twist);
      end else if (kind < 73) begin
        // Damage a family that would hold: drop a member or nudge one
        if ($urandom_range(1) == 0) begin
          add_subsets(pick_elements($urandom_range(3, 2)), -1, twist);
        end else begin
          n = $urandom_range(5, 3);
          add_subsets(pick_elements(n), $urandom_range(n - 1, 1), twist);
        end
        idx = $urandom_range(family.size() - 1);
        if ($urandom_range(1) == 0 && family.size() > 1)
          family.delete(idx);
        else
          family[idx] = family[idx] ^ pick_elements(1);
      end else if (kind < 88) begin
        base = set_mask_t'($urandom);
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(9) < 7)
            family = {family, base ^ pick_elements($urandom_range(3))};
          else
            family = {family, set_mask_t'($urandom)};
        end
      end else begin
        add_subsets(pick_elements($urandom_range(2)), -1, twist);
        repeat ($urandom_range(4, 1))
          family = {family, family[$urandom_range(family.size() - 1)]};
      end
      shuffle_family();
      send_family();
      runs++;
    end
    in_ch.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    // Let the map wipe after the final check run out
    repeat (300) @(posedge clk);
    sb.report_leftover();
    $display("checked %0d families from %0d sets: %0d satisfied the exchange axiom, %0d did not",
             sb.checks, sets_sent, sb.held, sb.checks - sb.held);
    $display("%0d families ran past the %0d-entry store", sb.overflows, DMX_MAX_SETS);
    if (sb.errors == 0) begin
      $display("delta_matroid_exchange_check_unit_test passed");
    end else begin
      $display("delta_matroid_exchange_check_unit_test failed");
    end
    $finish;
  end

endmodule

### delta_matroid_exchange_check_unit.f
+incdir+sv
sv/dmx_pkg.sv
sv/dmx_if.sv
sv/dmx_ram.sv
sv/dmx_probe.sv
sv/delta_matroid_exchange_check_unit.sv
bench/delta_matroid_exchange_check_unit_test.sv
